// ===== sv/sva_pkg.sv =====
package sva_pkg;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_PLAY   = 3'd1,
    OP_STOP   = 3'd2,
    OP_SETVOL = 3'd3,
    OP_PAUSE  = 3'd4,
    OP_RESUME = 3'd5,
    OP_PITCH  = 3'd6,
    OP_NOP    = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_VOLUME  = 3'd1,
    ACT_KEYON   = 3'd2,
    ACT_KEYOFF  = 3'd3,
    ACT_PITCH   = 3'd4,
    ACT_STORED  = 3'd5,
    ACT_NOVOICE = 3'd6,
    ACT_RSVD    = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_LOOP = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EX,
    S_EX2,
    S_FLUSH
  } state_t;

  localparam logic REG_MASTER = 1'b0;
  localparam logic REG_BASE   = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  voice;
    logic [7:0]  effect;
    logic [7:0]  volume;
    logic [15:0] pitch;
    logic [31:0] sample_offset;
    logic        entry_present;
    logic        entry_looping;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  target_voice;
    logic [13:0] left_level;
    logic [13:0] right_level;
    logic [15:0] pitch_word;
    logic [31:0] sample_address;
    logic        last;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] cached_left;
    logic [7:0] cached_right;
  } voice_ent_t;

  typedef struct packed {
    logic        present;
    logic        looping;
    logic [31:0] offset;
  } effect_ent_t;

  // n = pitch*3/2 - 1536, word = ((n<<1) & ~0xff) + (n & 127), low 16 bits
  function automatic logic [15:0] pitch_encode(input logic [15:0] pitch);
    logic [31:0] n;
    logic [31:0] w;
    n = ((32'(pitch) * 32'd3) >> 1) - 32'd1536;
    w = ((n << 1) & 32'hffffff00) + (n & 32'd127);
    return w[15:0];
  endfunction

endpackage

// ===== sv/sva_ram.sv =====
module sva_ram
  import sva_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sound_voice_allocator_core.sv =====
// Sound voice allocator.
// Input channel in_valid/in_stall carries one command transaction (in_data);
// the block takes one command at a time and stalls the input while it works.
// Output channel out_valid/out_stall returns zero or more result transactions
// per command; the final one has last set. A single output register holds the
// result; a result is loaded only when that register is empty or taken.
// cfg_we/cfg_index/cfg_wdata write master volume (index 0) and sample base
// (index 1); write only while no command is in flight.
// Flow: single-result commands pass S_RD and load their result in S_EX once
// the output register is free. Play walks the voice memory one voice per cycle,
// checking up to NUM_VOICES voices. Pause walks all voices, one per cycle unless
// a held result cannot move to the output register; resume passes S_EX and S_EX2
// for each looping voice (two chained master products) and only S_EX for others.
// Reset: after rst_n the effect memory is cleared, one entry a cycle, for all
// NUM_EFFECTS entries; no command is taken before that pass ends. Voice
// state is cleared at once through per-voice valid bits.
// Output stall holds the walk only where a result must move; nothing is dropped or repeated.
module sound_voice_allocator_core
  import sva_pkg::*;
#(
  parameter int NUM_VOICES  = 24,
  parameter int NUM_EFFECTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int VW = $clog2(NUM_VOICES);
  localparam int EW = $clog2(NUM_EFFECTS);
  localparam logic [VW-1:0] VLAST = VW'(NUM_VOICES - 1);
  localparam logic [EW-1:0] ELAST = EW'(NUM_EFFECTS - 1);

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] tries_r, tries_nxt;
  logic [VW-1:0] cursor_r, cursor_nxt;
  logic [EW-1:0] clr_r, clr_nxt;
  logic [7:0] master_r, master_nxt;
  logic [31:0] base_r, base_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic pend_v_r, pend_v_nxt;
  out_item_t pend_r, pend_nxt;
  logic [8:0] fhi_r, fhi_nxt;
  logic [NUM_VOICES-1:0] vvalid_r;
  logic vld_rd_r;

  // memories
  logic vwe;
  voice_ent_t vwdata, vq, vrd;
  logic ewe;
  effect_ent_t ewdata, erd;
  logic [EW-1:0] eaddr;
  logic [$bits(voice_ent_t)-1:0] vq_raw;
  logic [$bits(effect_ent_t)-1:0] eq_raw;

  logic in_acc, slot_free, pend_ok, at_end, search_last;
  logic eff_ok_in, voice_ok_in, eff_ok;
  logic out_load;
  out_item_t out_new;
  logic [14:0] play_prod;
  logic [6:0]  play_lvl;
  logic [15:0] vol_prod;
  logic [15:0] f_prod;
  logic [16:0] s_prod;

  sva_ram #(.WIDTH($bits(voice_ent_t)), .DEPTH(NUM_VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (idx_r),
    .wdata (vwdata),
    .raddr (idx_nxt),
    .rdata (vq_raw)
  );

  sva_ram #(.WIDTH($bits(effect_ent_t)), .DEPTH(NUM_EFFECTS)) u_effect_ram (
    .clk   (clk),
    .we    (ewe),
    .waddr (eaddr),
    .wdata (ewdata),
    .raddr (eaddr),
    .rdata (eq_raw)
  );

  assign vq  = voice_ent_t'(vq_raw);
  assign erd = effect_ent_t'(eq_raw);
  // never-written voices read as free with zero caches
  assign vrd = vld_rd_r ? vq : '0;

  // effect memory port follows the clearing counter, then the held command
  assign eaddr = (state_r == S_CLEAR) ? clr_r : EW'(item_nxt.effect);

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign slot_free   = !out_valid_r || !out_stall;
  assign pend_ok     = !pend_v_r || slot_free;
  assign at_end      = (idx_r == VLAST);
  assign search_last = (tries_r == VLAST);
  assign eff_ok_in   = (32'(in_data.effect) < NUM_EFFECTS);
  assign voice_ok_in = (32'(in_data.voice) < NUM_VOICES);
  assign eff_ok      = (32'(item_r.effect) < NUM_EFFECTS);

  assign play_prod = 15'(item_r.volume[7:1]) * 15'(master_r);
  assign play_lvl  = play_prod[14:8];
  assign vol_prod  = 16'(item_r.volume) * 16'(master_r);
  assign f_prod    = 16'(vrd.cached_right) * 16'(master_r);
  assign s_prod    = 17'(fhi_r) * 17'(master_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == ELAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (opcode_t'(in_data.opcode))
            OP_LOAD:                     if (eff_ok_in) state_nxt = S_RD;
            OP_PLAY, OP_PAUSE, OP_RESUME: state_nxt = S_RD;
            OP_STOP, OP_SETVOL, OP_PITCH: if (voice_ok_in) state_nxt = S_RD;
            default:                     state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        case (opcode_t'(item_r.opcode))
          OP_PLAY: begin
            if (vrd.kind != KIND_LOOP || search_last) begin
              if (slot_free) state_nxt = S_IDLE;
            end
          end
          OP_PAUSE: begin
            if ((vrd.kind == KIND_ONE || vrd.kind == KIND_LOOP) && !pend_ok) begin
              state_nxt = S_EX;
            end else if (at_end) begin
              state_nxt = S_FLUSH;
            end
          end
          OP_RESUME: begin
            if (vrd.kind == KIND_LOOP) state_nxt = S_EX2;
            else if (at_end)           state_nxt = S_FLUSH;
          end
          OP_LOAD, OP_STOP, OP_SETVOL, OP_PITCH: begin
            if (slot_free) state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_EX2: begin
        if (pend_ok) state_nxt = at_end ? S_FLUSH : S_EX;
      end
      S_FLUSH: begin
        if (!pend_v_r || slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    item_nxt   = item_r;
    idx_nxt    = idx_r;
    tries_nxt  = tries_r;
    cursor_nxt = cursor_r;
    clr_nxt    = clr_r;
    master_nxt = master_r;
    base_nxt   = base_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    fhi_nxt    = fhi_r;
    vwe        = 1'b0;
    vwdata     = '0;
    ewe        = 1'b0;
    ewdata     = '0;
    out_load   = 1'b0;
    out_new    = '0;

    if (cfg_we) begin
      case (cfg_index)
        REG_MASTER: master_nxt = cfg_wdata[7:0];
        REG_BASE:   base_nxt   = cfg_wdata;
        default:    base_nxt   = base_r;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        ewe     = 1'b1;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          item_nxt  = in_data;
          tries_nxt = '0;
          case (opcode_t'(in_data.opcode))
            OP_PLAY:                      idx_nxt = (cursor_r == VLAST) ? '0 : cursor_r + 1'b1;
            OP_PAUSE, OP_RESUME:          idx_nxt = '0;
            OP_STOP, OP_SETVOL, OP_PITCH: idx_nxt = VW'(in_data.voice);
            default:                      idx_nxt = idx_r;
          endcase
        end
      end
      S_EX: begin
        case (opcode_t'(item_r.opcode))
          OP_LOAD: begin
            if (slot_free) begin
              ewe             = 1'b1;
              ewdata.present  = item_r.entry_present;
              ewdata.looping  = item_r.entry_looping;
              ewdata.offset   = item_r.sample_offset;
              out_load        = 1'b1;
              out_new.action  = ACT_STORED;
              out_new.last    = 1'b1;
            end
          end
          OP_PLAY: begin
            if (vrd.kind != KIND_LOOP) begin
              if (slot_free) begin
                vwe                  = 1'b1;
                cursor_nxt           = idx_r;
                out_load             = 1'b1;
                out_new.target_voice = 5'(idx_r);
                out_new.last         = 1'b1;
                if (eff_ok && erd.present) begin
                  vwdata.kind           = erd.looping ? KIND_LOOP : KIND_ONE;
                  vwdata.cached_left    = {1'b0, play_lvl};
                  vwdata.cached_right   = {1'b0, play_lvl};
                  out_new.action        = ACT_KEYON;
                  out_new.left_level    = {play_lvl, 7'd0};
                  out_new.right_level   = {play_lvl, 7'd0};
                  out_new.pitch_word    = pitch_encode(item_r.pitch);
                  out_new.sample_address = base_r + erd.offset;
                end else begin
                  out_new.action = ACT_KEYOFF;
                end
              end
            end else if (search_last) begin
              if (slot_free) begin
                out_load             = 1'b1;
                out_new.action       = ACT_NOVOICE;
                out_new.target_voice = 5'(cursor_r);
                out_new.last         = 1'b1;
              end
            end else begin
              idx_nxt   = (idx_r == VLAST) ? '0 : idx_r + 1'b1;
              tries_nxt = tries_r + 1'b1;
            end
          end
          OP_STOP: begin
            if (slot_free) begin
              vwe                  = 1'b1;
              out_load             = 1'b1;
              out_new.action       = ACT_KEYOFF;
              out_new.target_voice = 5'(idx_r);
              out_new.last         = 1'b1;
            end
          end
          OP_SETVOL: begin
            if (slot_free) begin
              vwe                  = 1'b1;
              vwdata.kind          = vrd.kind;
              vwdata.cached_left   = {1'b0, vol_prod[15:9]};
              vwdata.cached_right  = {1'b0, vol_prod[15:9]};
              out_load             = 1'b1;
              out_new.action       = ACT_VOLUME;
              out_new.target_voice = 5'(idx_r);
              out_new.left_level   = {vol_prod[15:8], 6'd0};
              out_new.right_level  = {vol_prod[15:8], 6'd0};
              out_new.last         = 1'b1;
            end
          end
          OP_PITCH: begin
            if (slot_free) begin
              out_load             = 1'b1;
              out_new.action       = ACT_PITCH;
              out_new.target_voice = 5'(idx_r);
              out_new.pitch_word   = pitch_encode(item_r.pitch);
              out_new.last         = 1'b1;
            end
          end
          OP_PAUSE: begin
            if (vrd.kind == KIND_ONE || vrd.kind == KIND_LOOP) begin
              if (pend_ok) begin
                // older result leaves, this one waits to learn if it is last
                if (pend_v_r) begin
                  out_load = 1'b1;
                  out_new  = pend_r;
                end
                pend_v_nxt              = 1'b1;
                pend_nxt                = '0;
                pend_nxt.target_voice   = 5'(idx_r);
                if (vrd.kind == KIND_ONE) begin
                  vwe             = 1'b1;
                  pend_nxt.action = ACT_KEYOFF;
                end else begin
                  pend_nxt.action = ACT_VOLUME;
                end
                if (!at_end) idx_nxt = idx_r + 1'b1;
              end
            end else if (!at_end) begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          OP_RESUME: begin
            if (vrd.kind == KIND_LOOP) begin
              // (2 * right * master) >> 8
              fhi_nxt = f_prod[15:7];
            end else if (!at_end) begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: idx_nxt = idx_r;
        endcase
      end
      S_EX2: begin
        // second master product of resume
        if (pend_ok) begin
          if (pend_v_r) begin
            out_load = 1'b1;
            out_new  = pend_r;
          end
          vwe                  = 1'b1;
          vwdata.kind          = KIND_LOOP;
          vwdata.cached_left   = fhi_r[8:1];
          vwdata.cached_right  = s_prod[16:9];
          pend_v_nxt           = 1'b1;
          pend_nxt             = '0;
          pend_nxt.action      = ACT_VOLUME;
          pend_nxt.target_voice = 5'(idx_r);
          pend_nxt.left_level  = {fhi_r[7:0], 6'd0};
          pend_nxt.right_level = {s_prod[15:8], 6'd0};
          if (!at_end) idx_nxt = idx_r + 1'b1;
        end
      end
      S_FLUSH: begin
        if (pend_v_r && slot_free) begin
          out_load     = 1'b1;
          out_new      = pend_r;
          out_new.last = 1'b1;
          pend_v_nxt   = 1'b0;
        end
      end
      default: idx_nxt = idx_r;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);
  assign out_nxt       = out_load ? out_new : out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cursor_r    <= '0;
      clr_r       <= '0;
      master_r    <= 8'd255;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      vvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      clr_r       <= clr_nxt;
      master_r    <= master_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      if (vwe) vvalid_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    idx_r    <= idx_nxt;
    tries_r  <= tries_nxt;
    out_r    <= out_nxt;
    pend_r   <= pend_nxt;
    fhi_r    <= fhi_nxt;
    vld_rd_r <= vvalid_r[idx_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
